/* rtl/core/mwsa_pkg.sv */
// shared types and constants of the mosaic wipe sample address block
package mwsa_pkg;

    // fixed field widths
    localparam int PIX_W    = 12;
    localparam int ADDR_W   = 24;
    localparam int FRAME_W  = 16;
    localparam int OFFSET_W = 6;
    localparam int PITCH_W  = 13;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

    // register reset values
    localparam logic [FRAME_W-1:0] FRAME_COUNT_RST = 16'd0;
    localparam logic [FRAME_W-1:0] FRAME_TOTAL_RST = 16'd1;
    localparam logic [PITCH_W-1:0] PITCH_RST       = 13'd640;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_COUNT  = 3'd0,
        CFG_FRAME_TOTAL  = 3'd1,
        CFG_OFFSET_X     = 3'd2,
        CFG_OFFSET_Y     = 3'd3,
        CFG_START_ORIGIN = 3'd4,
        CFG_END_ORIGIN   = 3'd5,
        CFG_START_PITCH  = 3'd6,
        CFG_END_PITCH    = 3'd7
    } t_cfg_reg;

endpackage

/* rtl/core/mwsa_pix_if.sv */
// pixel coordinate channel
interface mwsa_pix_if;
    logic                      valid;
    logic                      ready;
    logic [mwsa_pkg::PIX_W-1:0] pixel_x;
    logic [mwsa_pkg::PIX_W-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

/* rtl/core/mwsa_res_if.sv */
// sample address result channel
interface mwsa_res_if #(
    parameter int BLOCK_W = 7
);
    logic                        valid;
    logic                        ready;
    logic [mwsa_pkg::ADDR_W-1:0] source_address;
    logic                        use_end_picture;
    logic [BLOCK_W-1:0]          block_size;
    logic                        address_overflow;

    modport source (output valid, output source_address, output use_end_picture,
                    output block_size, output address_overflow, input ready);
    modport sink   (input valid, input source_address, input use_end_picture,
                    input block_size, input address_overflow, output ready);
endinterface

/* rtl/core/mosaic_wipe_sample_address.sv */
// mosaic wipe sample address: top level pipeline
//
// Takes one screen pixel coordinate per clock and returns, for each one, the
// linear address of the source pixel a mosaic wipe shows there, with the block
// size in use, which picture is sampled and an overflow flag (the address then
// saturates to all ones). The block size grows from 1 to MAX_BLOCK over the
// first half of the wipe and shrinks back over the second half, which samples
// the end picture; a block size of 1 is a plain copy. Throughput is one item
// per clock while the result side is not stalled. The pipeline is built around
// bit-per-stage restoring dividers: one for the block size against the wipe
// half length, then one per coordinate for the block remainder. A stall on the
// result side holds the whole pipeline and drops input ready in the same cycle.
// Configuration may only be written while no item is in flight; the block-size
// pipeline reads it live.
module mosaic_wipe_sample_address #(
    parameter int MAX_BLOCK  = 64,
    parameter int COORD_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mwsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mwsa_pkg::CFG_W-1:0]        i_cfg_data,
    mwsa_pix_if.sink                          i_pix,
    mwsa_res_if.source                        o_res
);

    // derived widths
    localparam int QW  = $clog2(MAX_BLOCK);               // block size quotient bits
    localparam int BW  = $clog2(MAX_BLOCK + 1);           // block size bits
    localparam int XW  = (COORD_BITS < mwsa_pkg::PIX_W) ? COORD_BITS : mwsa_pkg::PIX_W;
    localparam int OYW = (COORD_BITS < mwsa_pkg::ADDR_W - COORD_BITS) ?
                         COORD_BITS : mwsa_pkg::ADDR_W - COORD_BITS;
    localparam int SW  = COORD_BITS + 2;                  // sample coordinate sum
    localparam int PW  = SW + mwsa_pkg::PITCH_W;          // row offset product
    localparam int NW  = mwsa_pkg::FRAME_W + 1 + BW;      // block size dividend
    localparam int FW  = mwsa_pkg::FRAME_W;

    // configuration registers
    logic [FW-1:0]                       r_frame_count;
    logic [FW-1:0]                       r_frame_total;
    logic [mwsa_pkg::OFFSET_W-1:0]       r_offset_x;
    logic [mwsa_pkg::OFFSET_W-1:0]       r_offset_y;
    logic [mwsa_pkg::ADDR_W-1:0]         r_start_origin;
    logic [mwsa_pkg::ADDR_W-1:0]         r_end_origin;
    logic [mwsa_pkg::PITCH_W-1:0]        r_start_pitch;
    logic [mwsa_pkg::PITCH_W-1:0]        r_end_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count  <= mwsa_pkg::FRAME_COUNT_RST;
            r_frame_total  <= mwsa_pkg::FRAME_TOTAL_RST;
            r_offset_x     <= '0;
            r_offset_y     <= '0;
            r_start_origin <= '0;
            r_end_origin   <= '0;
            r_start_pitch  <= mwsa_pkg::PITCH_RST;
            r_end_pitch    <= mwsa_pkg::PITCH_RST;
        end else if (i_cfg_we) begin
            unique case (mwsa_pkg::t_cfg_reg'(i_cfg_idx))
                mwsa_pkg::CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_data[FW-1:0];
                mwsa_pkg::CFG_FRAME_TOTAL:  r_frame_total  <= i_cfg_data[FW-1:0];
                mwsa_pkg::CFG_OFFSET_X:     r_offset_x     <= i_cfg_data[mwsa_pkg::OFFSET_W-1:0];
                mwsa_pkg::CFG_OFFSET_Y:     r_offset_y     <= i_cfg_data[mwsa_pkg::OFFSET_W-1:0];
                mwsa_pkg::CFG_START_ORIGIN: r_start_origin <= i_cfg_data[mwsa_pkg::ADDR_W-1:0];
                mwsa_pkg::CFG_END_ORIGIN:   r_end_origin   <= i_cfg_data[mwsa_pkg::ADDR_W-1:0];
                mwsa_pkg::CFG_START_PITCH:  r_start_pitch  <= i_cfg_data[mwsa_pkg::PITCH_W-1:0];
                mwsa_pkg::CFG_END_PITCH:    r_end_pitch    <= i_cfg_data[mwsa_pkg::PITCH_W-1:0];
                default: ;
            endcase
        end
    end

    // wipe position: half length and clamped step count
    logic [FW-1:0] w_total;
    logic [FW-1:0] w_half;
    logic [FW-1:0] w_limit;
    logic          w_second;
    logic [FW-1:0] w_c_raw;
    logic [FW-1:0] n_c;

    always_comb begin
        w_total  = (r_frame_total == '0) ? FW'(1) : r_frame_total;
        w_half   = w_total >> 1;
        w_limit  = (w_half == '0) ? FW'(1) : w_half;
        w_second = (r_frame_count >= w_limit);
        if (w_second) begin
            w_c_raw = (w_total >= r_frame_count) ? (w_total - r_frame_count) : '0;
        end else begin
            w_c_raw = r_frame_count;
        end
        n_c = (w_c_raw > w_limit) ? w_limit : w_c_raw;
    end

    // whole pipeline moves together; a stalled result holds everything
    logic r_o_vld;
    logic w_en;

    assign w_en        = !r_o_vld || o_res.ready;
    assign i_pix.ready = w_en && i_rst_n;

    // stage a: captured coordinate and wipe step
    logic          r_a_vld;
    logic [XW-1:0] r_a_x;
    logic [XW-1:0] r_a_y;
    logic          r_a_end;
    logic [FW-1:0] r_a_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_pix.valid;
            r_a_x   <= i_pix.pixel_x[XW-1:0];
            r_a_y   <= i_pix.pixel_y[XW-1:0];
            r_a_end <= w_second;
            r_a_c   <= n_c;
        end
    end

    // block size divider: ((c + 1) * MAX_BLOCK) / limit, one quotient bit a stage
    logic          r_q_vld  [0:QW];
    logic [XW-1:0] r_q_x    [0:QW];
    logic [XW-1:0] r_q_y    [0:QW];
    logic          r_q_end  [0:QW];
    logic          r_q_full [0:QW];
    logic [FW-1:0] r_q_rem  [0:QW];
    logic [QW-1:0] r_q_low  [0:QW];
    logic [QW-1:0] r_q_quo  [0:QW];

    logic [FW:0]   w_c1;
    logic [NW-1:0] w_num;
    logic          n_full;

    always_comb begin
        w_c1   = {1'b0, r_a_c} + (FW+1)'(1);
        n_full = (w_c1 >= {1'b0, w_limit});        // quotient saturates at MAX_BLOCK
        w_num  = NW'(w_c1) * NW'(MAX_BLOCK);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_q_vld[0]  <= r_a_vld;
            r_q_x[0]    <= r_a_x;
            r_q_y[0]    <= r_a_y;
            r_q_end[0]  <= r_a_end;
            r_q_full[0] <= n_full;
            r_q_rem[0]  <= w_num[QW+FW-1:QW];      // below limit when not saturated
            r_q_low[0]  <= w_num[QW-1:0];
            r_q_quo[0]  <= '0;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_div
        logic [FW:0] n_t;
        logic        n_ge;
        logic [QW:0] n_quo;
        logic [QW:0] n_low;

        always_comb begin
            n_t   = {r_q_rem[k-1], r_q_low[k-1][QW-1]};
            n_ge  = (n_t >= {1'b0, w_limit});
            n_quo = {r_q_quo[k-1], n_ge};
            n_low = {r_q_low[k-1], 1'b0};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_q_vld[k]  <= r_q_vld[k-1];
                r_q_x[k]    <= r_q_x[k-1];
                r_q_y[k]    <= r_q_y[k-1];
                r_q_end[k]  <= r_q_end[k-1];
                r_q_full[k] <= r_q_full[k-1];
                r_q_rem[k]  <= n_ge ? FW'(n_t - {1'b0, w_limit}) : n_t[FW-1:0];
                r_q_low[k]  <= n_low[QW-1:0];
                r_q_quo[k]  <= n_quo[QW-1:0];
            end
        end
    end

    // coordinate dividers: x mod b and y mod b, one coordinate bit a stage
    logic          r_k_vld  [0:XW];
    logic [XW-1:0] r_k_x    [0:XW];
    logic [XW-1:0] r_k_y    [0:XW];
    logic          r_k_end  [0:XW];
    logic [BW-1:0] r_k_b    [0:XW];
    logic [BW-1:0] r_k_remx [0:XW];
    logic [BW-1:0] r_k_remy [0:XW];

    logic [BW-1:0] n_b;

    always_comb begin
        if (r_q_full[QW]) begin
            n_b = BW'(MAX_BLOCK);
        end else if (r_q_quo[QW] == '0) begin
            n_b = BW'(1);
        end else begin
            n_b = BW'(r_q_quo[QW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_k_vld[0]  <= r_q_vld[QW];
            r_k_x[0]    <= r_q_x[QW];
            r_k_y[0]    <= r_q_y[QW];
            r_k_end[0]  <= r_q_end[QW];
            r_k_b[0]    <= n_b;
            r_k_remx[0] <= '0;
            r_k_remy[0] <= '0;
        end
    end

    for (genvar k = 1; k <= XW; k++) begin : g_mod
        logic [BW:0] n_tx;
        logic [BW:0] n_ty;
        logic        n_gex;
        logic        n_gey;

        always_comb begin
            n_tx  = {r_k_remx[k-1], r_k_x[k-1][XW-k]};
            n_ty  = {r_k_remy[k-1], r_k_y[k-1][XW-k]};
            n_gex = (n_tx >= {1'b0, r_k_b[k-1]});
            n_gey = (n_ty >= {1'b0, r_k_b[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_k_vld[k] <= 1'b0;
            end else if (w_en) begin
                r_k_vld[k]  <= r_k_vld[k-1];
                r_k_x[k]    <= r_k_x[k-1];
                r_k_y[k]    <= r_k_y[k-1];
                r_k_end[k]  <= r_k_end[k-1];
                r_k_b[k]    <= r_k_b[k-1];
                r_k_remx[k] <= n_gex ? BW'(n_tx - {1'b0, r_k_b[k-1]}) : n_tx[BW-1:0];
                r_k_remy[k] <= n_gey ? BW'(n_ty - {1'b0, r_k_b[k-1]}) : n_ty[BW-1:0];
            end
        end
    end

    // stage e: sample coordinates in the chosen picture
    logic                         r_e_vld;
    logic                         r_e_end;
    logic [BW-1:0]                r_e_b;
    logic [SW-1:0]                r_e_sx;
    logic [SW-1:0]                r_e_sy;
    logic [mwsa_pkg::PITCH_W-1:0] r_e_pitch;

    logic [mwsa_pkg::ADDR_W-1:0]  w_origin;
    logic [COORD_BITS-1:0]        w_ox;
    logic [OYW-1:0]               w_oy;
    logic [mwsa_pkg::OFFSET_W-1:0] w_offx;
    logic [mwsa_pkg::OFFSET_W-1:0] w_offy;
    logic [XW-1:0]                w_bx;
    logic [XW-1:0]                w_by;
    logic [SW-1:0]                n_sx;
    logic [SW-1:0]                n_sy;

    always_comb begin
        w_origin = r_k_end[XW] ? r_end_origin : r_start_origin;
        w_ox     = w_origin[COORD_BITS-1:0];
        w_oy     = w_origin[COORD_BITS+OYW-1:COORD_BITS];
        // plain copy: no sample offset
        w_offx   = (r_k_b[XW] == BW'(1)) ? '0 : r_offset_x;
        w_offy   = (r_k_b[XW] == BW'(1)) ? '0 : r_offset_y;
        // block corner = coordinate less its remainder
        w_bx     = r_k_x[XW] - XW'(r_k_remx[XW]);
        w_by     = r_k_y[XW] - XW'(r_k_remy[XW]);
        n_sx     = SW'(w_ox) + SW'(w_bx) + SW'(w_offx);
        n_sy     = SW'(w_oy) + SW'(w_by) + SW'(w_offy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld   <= r_k_vld[XW];
            r_e_end   <= r_k_end[XW];
            r_e_b     <= r_k_b[XW];
            r_e_sx    <= n_sx;
            r_e_sy    <= n_sy;
            r_e_pitch <= r_k_end[XW] ? r_end_pitch : r_start_pitch;
        end
    end

    // stage f: row offset product
    logic          r_f_vld;
    logic          r_f_end;
    logic [BW-1:0] r_f_b;
    logic [SW-1:0] r_f_sx;
    logic [PW-1:0] r_f_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= r_e_vld;
            r_f_end <= r_e_end;
            r_f_b   <= r_e_b;
            r_f_sx  <= r_e_sx;
            r_f_row <= PW'(r_e_sy) * PW'(r_e_pitch);
        end
    end

    // output stage: final address with saturation
    logic [mwsa_pkg::ADDR_W-1:0] r_o_addr;
    logic                        r_o_end;
    logic [BW-1:0]               r_o_b;
    logic                        r_o_ovf;

    logic [PW:0]                 w_addr;
    logic                        n_ovf;

    always_comb begin
        w_addr = (PW+1)'(r_f_sx) + (PW+1)'(r_f_row);
        n_ovf  = (w_addr > (PW+1)'(mwsa_pkg::ADDR_MAX));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld  <= r_f_vld;
            r_o_end  <= r_f_end;
            r_o_b    <= r_f_b;
            r_o_ovf  <= n_ovf;
            r_o_addr <= n_ovf ? mwsa_pkg::ADDR_MAX : w_addr[mwsa_pkg::ADDR_W-1:0];
        end
    end

    assign o_res.valid            = r_o_vld;
    assign o_res.source_address   = r_o_addr;
    assign o_res.use_end_picture  = r_o_end;
    assign o_res.block_size       = r_o_b;
    assign o_res.address_overflow = r_o_ovf;

    // checks
    a_rem_below_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k_vld[XW] |-> (r_k_remx[XW] < r_k_b[XW]) && (r_k_remy[XW] < r_k_b[XW]))
        else $error("coordinate remainder not below block size");

    a_block_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.block_size >= BW'(1)) && (o_res.block_size <= BW'(MAX_BLOCK)))
        else $error("block size out of range");

    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.address_overflow |-> o_res.source_address == mwsa_pkg::ADDR_MAX)
        else $error("overflow without saturated address");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.valid && i_pix.ready |=> r_a_vld)
        else $error("accepted item missing from first stage");

    a_last_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && r_f_vld |=> o_res.valid)
        else $error("item lost before output stage");

endmodule
